FILE: rtl/sbfd_pkg.sv
`timescale 1ns / 1ps

package sbfd_pkg;

  localparam int FRAME_BYTES     = 25;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [4:0] FLAG_POS      = 5'(FRAME_BYTES - 2);
  localparam logic [4:0] LAST_DATA_POS = 5'(FRAME_BYTES - 3);
  localparam logic [4:0] FIRST_DATA_POS = 5'd1;
  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam logic [4:0] AUTO_CHANNEL  = 5'd4;
  localparam logic [4:0] CH_DIG0       = 5'd16;
  localparam logic [4:0] CH_DIG1       = 5'd17;
  localparam logic [4:0] CH_BITS       = 5'd11;
  localparam logic [4:0] MAX_LEFT_BITS = 5'd10;
  localparam logic [4:0] MAX_ANALOG_CH = 5'd16;

  localparam logic [7:0]  START_VALUE_RST    = 8'h0F;
  localparam logic [10:0] AUTONOMY_VALUE_RST = 11'd1811;

  typedef enum logic [0:0] {
    REG_START_VALUE    = 1'b0,
    REG_AUTONOMY_VALUE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        is_flag;
    logic [4:0]  chan;
    logic [10:0] value;
    logic [3:0]  flags;
    logic        autonomy;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  chan;
    logic [10:0] value;
    logic        done;
    logic        lost;
    logic        failsafe;
    logic        autonomy;
  } res_t;

endpackage

FILE: rtl/sbfd_front.sv
`timescale 1ns / 1ps

module sbfd_front import sbfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        accept,
  input  logic [7:0]  byte_value,
  input  logic        frame_start,
  output logic        cmd_valid,
  output cmd_t        cmd
);

  logic [7:0]  start_r;
  logic [10:0] auto_r;
  logic [4:0]  pos_r,  pos_nxt;
  logic [17:0] acc_r,  acc_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [4:0]  ch_r,   ch_nxt;
  logic        hv_r,   hv_nxt;
  logic        seen_r, seen_nxt;
  logic [17:0] merged;
  logic [4:0]  sum_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_VALUE_RST;
      auto_r  <= AUTONOMY_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_VALUE:    start_r <= cfg_wdata[7:0];
        REG_AUTONOMY_VALUE: auto_r  <= cfg_wdata;
        default:            start_r <= start_r;
      endcase
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    bits_nxt  = bits_r;
    ch_nxt    = ch_r;
    hv_nxt    = hv_r;
    seen_nxt  = seen_r;
    cmd_valid = 1'b0;
    cmd       = '0;
    merged    = acc_r | ({10'b0, byte_value} << bits_r[3:0]);
    sum_bits  = bits_r + 5'd8;
    if (accept) begin
      if (frame_start) begin
        hv_nxt   = (byte_value == start_r);
        acc_nxt  = '0;
        bits_nxt = '0;
        ch_nxt   = '0;
        seen_nxt = 1'b0;
        pos_nxt  = FIRST_DATA_POS;
      end else begin
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end
        if (hv_r) begin
          if (pos_r >= FIRST_DATA_POS && pos_r <= LAST_DATA_POS) begin
            acc_nxt  = merged;
            bits_nxt = sum_bits;
            if (sum_bits >= CH_BITS) begin
              cmd_valid = 1'b1;
              cmd.chan  = ch_r;
              cmd.value = merged[10:0];
              if (ch_r == AUTO_CHANNEL) begin
                seen_nxt = (merged[10:0] == auto_r);
              end
              acc_nxt  = {11'b0, merged[17:11]};
              bits_nxt = sum_bits - CH_BITS;
              ch_nxt   = ch_r + 5'd1;
            end
          end else if (pos_r == FLAG_POS) begin
            cmd_valid    = 1'b1;
            cmd.is_flag  = 1'b1;
            cmd.flags    = byte_value[3:0];
            cmd.autonomy = seen_r;
            hv_nxt       = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      acc_r  <= '0;
      bits_r <= '0;
      ch_r   <= '0;
      hv_r   <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      acc_r  <= acc_nxt;
      bits_r <= bits_nxt;
      ch_r   <= ch_nxt;
      hv_r   <= hv_nxt;
      seen_r <= seen_nxt;
    end
  end

`ifndef SYNTHESIS
  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= MAX_LEFT_BITS) else $error("leftover bit count too large");
  a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && !cmd.is_flag |-> cmd.chan < MAX_ANALOG_CH)
    else $error("analog channel index out of range");
`endif

endmodule

FILE: rtl/sbfd_queue.sv
`timescale 1ns / 1ps

module sbfd_queue import sbfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic valid,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign dout  = mem_r[rd_ptr_r];
  assign valid = (count_r != '0);
  assign full  = (count_r == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count overflow");
`endif

endmodule

FILE: rtl/sbfd_back.sv
`timescale 1ns / 1ps

module sbfd_back import sbfd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  input  logic out_pop,
  output logic out_empty,
  output res_t res
);

  logic out_valid_r, out_valid_nxt;
  logic phase_r, phase_nxt;
  res_t res_r, res_nxt;
  logic load;

  assign load      = q_valid && (!out_valid_r || out_pop);
  assign q_pop     = load && (!q_head.is_flag || phase_r);
  assign out_empty = !out_valid_r;
  assign res       = res_r;

  always_comb begin
    res_nxt       = '0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    if (q_head.is_flag) begin
      if (!phase_r) begin
        res_nxt.chan  = CH_DIG0;
        res_nxt.value = {10'b0, q_head.flags[0]};
      end else begin
        res_nxt.chan     = CH_DIG1;
        res_nxt.value    = {10'b0, q_head.flags[1]};
        res_nxt.done     = 1'b1;
        res_nxt.lost     = q_head.flags[2];
        res_nxt.failsafe = q_head.flags[3];
        res_nxt.autonomy = q_head.autonomy;
      end
    end else begin
      res_nxt.chan  = q_head.chan;
      res_nxt.value = q_head.value;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (q_head.is_flag) begin
        phase_nxt = !phase_r;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> q_valid && q_head.is_flag) else $error("split without flag entry");
  a_dig1_after_dig0: assert property (@(posedge clk) disable iff (!rst_n)
    load && phase_r |=> res_r.chan == CH_DIG1 && res_r.done)
    else $error("second digital result missing");
`endif

endmodule

FILE: rtl/sbus_frame_decoder_top.sv
`timescale 1ns / 1ps
// Receiver frame decoder.
// Input channel: one byte per request on in_byte_value, with in_frame_start set
// on the first byte of each frame. A byte is taken when in_push is high and
// in_full is low.
// Result channel: a queue read port. While out_empty is low the oldest result
// sits on the out_ ports; out_pop takes it. A frame with a good header gives
// sixteen analog results, then the two digital channels; the last carries
// out_frame_done with the lost-frame, failsafe and autonomy flags.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 start
// value, 1 autonomy value) on the same edge; write only while idle.
// A result passes through the command queue and then the output register.
// Throughput: one byte per cycle while in_full is low; the flag byte yields two
// results, sent in turn from one entry of the command queue between the byte
// decoder and the output stage. A stalled reader fills it, then in_full rises.
// Reset (rst_n low, synchronous) empties the queue and the output register,
// restores both configuration registers and drops any partial frame.
module sbus_frame_decoder_top import sbfd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte_value,
  input  logic        in_frame_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_channel_index,
  output logic [10:0] out_channel_value,
  output logic        out_frame_done,
  output logic        out_frame_lost,
  output logic        out_failsafe_active,
  output logic        out_autonomy_request
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  cmd_t q_head;
  logic q_valid;
  logic q_full;
  logic q_pop;
  res_t res;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  sbfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .byte_value  (in_byte_value),
    .frame_start (in_frame_start),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  sbfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_valid),
    .din   (cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .valid (q_valid),
    .full  (q_full)
  );

  sbfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .res       (res)
  );

  assign out_channel_index    = res.chan;
  assign out_channel_value    = res.value;
  assign out_frame_done       = res.done;
  assign out_frame_lost       = res.lost;
  assign out_failsafe_active  = res.failsafe;
  assign out_autonomy_request = res.autonomy;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sbfd_pkg::*;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       frame_start;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_START_VALUE;
  logic [10:0] cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_byte_value = '0;
  logic        in_frame_start = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [4:0]  out_channel_index;
  logic [10:0] out_channel_value;
  logic        out_frame_done;
  logic        out_frame_lost;
  logic        out_failsafe_active;
  logic        out_autonomy_request;

  sbus_frame_decoder_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_byte_value        (in_byte_value),
    .in_frame_start       (in_frame_start),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_channel_index    (out_channel_index),
    .out_channel_value    (out_channel_value),
    .out_frame_done       (out_frame_done),
    .out_frame_lost       (out_frame_lost),
    .out_failsafe_active  (out_failsafe_active),
    .out_autonomy_request (out_autonomy_request)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  byte_req_t   pending_bytes[$];
  res_t        expected_results[$];
  int          mismatch_count = 0;
  int          items_added = 0;

  logic [7:0]  model_start_value = START_VALUE_RST;
  logic [10:0] model_autonomy_value = AUTONOMY_VALUE_RST;
  logic [4:0]  frame_pos = '0;
  logic [17:0] bit_acc = '0;
  logic [4:0]  acc_count = '0;
  logic [4:0]  chan_next = '0;
  logic        header_ok = 1'b0;
  logic        autonomy_hit = 1'b0;

  function automatic void decode_byte(logic [7:0] b, logic first);
    logic [4:0]  cur_pos;
    logic [10:0] chan_val;
    res_t        r;
    if (first) begin
      header_ok    = (b == model_start_value);
      bit_acc      = '0;
      acc_count    = '0;
      chan_next    = '0;
      autonomy_hit = 1'b0;
      frame_pos    = FIRST_DATA_POS;
      return;
    end
    cur_pos = frame_pos;
    if (frame_pos < POS_MAX) frame_pos = frame_pos + 5'd1;
    if (!header_ok) return;
    if (cur_pos >= FIRST_DATA_POS && cur_pos <= LAST_DATA_POS) begin
      bit_acc   = bit_acc | (18'(b) << acc_count);
      acc_count = acc_count + 5'd8;
      if (acc_count >= CH_BITS) begin
        chan_val = bit_acc[10:0];
        if (chan_next == AUTO_CHANNEL) autonomy_hit = (chan_val == model_autonomy_value);
        r = '{chan: chan_next, value: chan_val, done: 1'b0, lost: 1'b0,
              failsafe: 1'b0, autonomy: 1'b0};
        expected_results.push_back(r);
        bit_acc   = bit_acc >> CH_BITS;
        acc_count = acc_count - CH_BITS;
        chan_next = chan_next + 5'd1;
      end
    end else if (cur_pos == FLAG_POS) begin
      r = '{chan: CH_DIG0, value: 11'(b[0]), done: 1'b0, lost: 1'b0,
            failsafe: 1'b0, autonomy: 1'b0};
      expected_results.push_back(r);
      r = '{chan: CH_DIG1, value: 11'(b[1]), done: 1'b1, lost: b[2],
            failsafe: b[3], autonomy: autonomy_hit};
      expected_results.push_back(r);
      header_ok = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && in_full)) begin
      if (in_push) begin
        decode_byte(in_byte_value, in_frame_start);
        void'(pending_bytes.pop_front());
      end
      if (gap_left != 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_push        <= 1'b1;
        in_byte_value  <= pending_bytes[0].byte_value;
        in_frame_start <= pending_bytes[0].frame_start;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  int   stall_left = 0;
  int   pop_cycle = 0;
  res_t want;

  always @(posedge clk) begin
    pop_cycle++;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_cycle % 1024 >= 800) begin
      out_pop <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      if ($urandom_range(0, 39) == 0) stall_left = $urandom_range(13, 30);
      else if ($urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result channel", out_channel_index, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_channel_index != want.chan)
          report_mismatch("channel_index", out_channel_index, want.chan);
        if (out_channel_value != want.value)
          report_mismatch("channel_value", out_channel_value, want.value);
        if (out_frame_done != want.done)
          report_mismatch("frame_done", out_frame_done, want.done);
        if (out_frame_lost != want.lost)
          report_mismatch("frame_lost", out_frame_lost, want.lost);
        if (out_failsafe_active != want.failsafe)
          report_mismatch("failsafe_active", out_failsafe_active, want.failsafe);
        if (out_autonomy_request != want.autonomy)
          report_mismatch("autonomy_request", out_autonomy_request, want.autonomy);
      end
    end
  end

  task automatic add_byte(logic [7:0] b, logic first);
    byte_req_t req;
    req.byte_value  = b;
    req.frame_start = first;
    pending_bytes.push_back(req);
    items_added++;
  endtask

  task automatic add_noise(int n, int start_odds);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom_range(0, 255)),
               start_odds != 0 && $urandom_range(0, start_odds - 1) == 0);
  endtask

  task automatic add_frame(logic [7:0] hdr, int body_len, bit alt_extremes,
                           bit force_auto, logic [7:0] flag_byte);
    logic [175:0] bits;
    logic [10:0]  v;
    int           pick;
    for (int c = 0; c < 16; c++) begin
      pick = $urandom_range(0, 5);
      if (alt_extremes) v = c[0] ? 11'h7FF : 11'h000;
      else if (pick == 0) v = 11'h000;
      else if (pick == 1) v = 11'h7FF;
      else v = 11'($urandom_range(0, 2047));
      if (c == AUTO_CHANNEL && force_auto) v = model_autonomy_value;
      bits[c*11 +: 11] = v;
    end
    add_byte(hdr, 1'b1);
    for (int i = 1; i <= body_len; i++) begin
      if (i <= LAST_DATA_POS) add_byte(bits[(i-1)*8 +: 8], 1'b0);
      else if (i == FLAG_POS) add_byte(flag_byte, 1'b0);
      else add_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic add_random_bytes(int n_items);
    int         target;
    int         kind;
    logic [7:0] bad_hdr;
    target = items_added + n_items;
    while (items_added < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        add_frame(model_start_value, FRAME_BYTES - 1, 1'b0, $urandom_range(0, 2) == 0,
                  8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) add_noise($urandom_range(8, 40), 0);
        else add_noise($urandom_range(0, 3), 0);
      end else if (kind < 75) begin
        add_frame(model_start_value, $urandom_range(1, 23), 1'b0,
                  $urandom_range(0, 1) == 0, 8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        bad_hdr = 8'($urandom_range(0, 255));
        while (bad_hdr == model_start_value) bad_hdr = 8'($urandom_range(0, 255));
        add_frame(bad_hdr, FRAME_BYTES - 1, 1'b0, 1'b0, 8'($urandom_range(0, 255)));
      end else begin
        add_noise($urandom_range(1, 8), 4);
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [10:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_START_VALUE:    model_start_value    = data[7:0];
      REG_AUTONOMY_VALUE: model_autonomy_value = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_push || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    add_noise(1, 0);
    add_frame(model_start_value, FLAG_POS, 1'b1, 1'b1, 8'hFF);
    add_frame(~model_start_value, 1, 1'b0, 1'b0, 8'h00);
    add_frame(model_start_value, 2, 1'b0, 1'b0, 8'h00);
    add_random_bytes(400);
    drain();

    write_reg(REG_START_VALUE, 11'h000);
    write_reg(REG_AUTONOMY_VALUE, 11'h000);
    add_random_bytes(400);
    drain();

    write_reg(REG_START_VALUE, 11'h7FF);
    write_reg(REG_AUTONOMY_VALUE, 11'h7FF);
    add_random_bytes(400);
    drain();

    write_reg(REG_START_VALUE, 11'($urandom_range(0, 2047)));
    write_reg(REG_AUTONOMY_VALUE, 11'($urandom_range(0, 2047)));
    add_random_bytes(400);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sbus_frame_decoder_top.f
rtl/sbfd_pkg.sv
rtl/sbfd_front.sv
rtl/sbfd_queue.sv
rtl/sbfd_back.sv
rtl/sbus_frame_decoder_top.sv
dv/tb_top.sv
